>>> sv/lo3_pkg.sv
// ----------------------------------------------------------------------------
// lo3_pkg
// Shared types and constants of the 3x3 Laplacian outline filter: request
// payloads, window column type, per-output control and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lo3_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 1024;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int PIX_W    = 8;
    localparam int WIN_ROWS = 3;
    localparam int WIN_COLS = 3;

    // results held or in flight before the input side is stalled
    localparam int OUT_QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef logic [PIX_W-1:0] t_pix;

    // one window column: [0] line above, [1] middle line, [2] current line
    typedef t_pix [WIN_ROWS-1:0] t_col3;

    typedef struct packed {
        logic mode;
        t_pix red_in;
    } t_in_item;

    typedef struct packed {
        t_pix gray_out;
        logic frame_last;
    } t_out_item;

    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line_word;

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_mask;

    typedef struct packed {
        t_mask mask;
        logic  last;
        logic  emit;
    } t_ctrl;

endpackage

`default_nettype wire

>>> sv/lo3_line_store.sv
// ----------------------------------------------------------------------------
// lo3_line_store
// Both line stores in one memory word per column: registered read, one write.
// ----------------------------------------------------------------------------
`default_nettype none

module lo3_line_store #(
    parameter int DEPTH = lo3_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                      i_clk,
    input  wire  [AW-1:0]            i_raddr,
    output lo3_pkg::t_line_word      o_rdata,
    input  wire                      i_we,
    input  wire  [AW-1:0]            i_waddr,
    input  lo3_pkg::t_line_word      i_wdata
);

    lo3_pkg::t_line_word r_mem [DEPTH];
    lo3_pkg::t_line_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/lo3_cell.sv
// ----------------------------------------------------------------------------
// lo3_cell
// One column of the 3x3 window; takes its neighbour's column on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lo3_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_shift,
    input  lo3_pkg::t_col3  i_col,
    output lo3_pkg::t_col3  o_col
);

    lo3_pkg::t_col3 r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

>>> sv/lo3_kernel.sv
// ----------------------------------------------------------------------------
// lo3_kernel
// Outline kernel over the window: eight times the centre less the neighbours
// that lie inside the frame, clamped to a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lo3_kernel (
    input  lo3_pkg::t_col3  i_left,
    input  lo3_pkg::t_col3  i_center,
    input  lo3_pkg::t_col3  i_right,
    input  lo3_pkg::t_mask  i_mask,
    output lo3_pkg::t_pix   o_gray
);

    localparam int SUM_W    = 12;
    localparam int GRAY_MAX = 255;

    lo3_pkg::t_col3           w_cols [lo3_pkg::WIN_COLS];
    logic [lo3_pkg::WIN_COLS-1:0] w_col_ok;
    logic [lo3_pkg::WIN_ROWS-1:0] w_row_ok;
    logic signed [SUM_W-1:0]  w_sum;

    assign w_cols[0] = i_left;
    assign w_cols[1] = i_center;
    assign w_cols[2] = i_right;

    assign w_col_ok = {i_mask.right_ok, 1'b1, i_mask.left_ok};
    assign w_row_ok = {i_mask.bot_ok, 1'b1, i_mask.top_ok};

    always_comb begin
        w_sum = $signed({1'b0, i_center[1], 3'b000});
        for (int i = 0; i < lo3_pkg::WIN_COLS; i++) begin
            for (int k = 0; k < lo3_pkg::WIN_ROWS; k++) begin
                if (w_col_ok[i] && w_row_ok[k] && !(i == 1 && k == 1)) begin
                    w_sum = w_sum - $signed({4'b0000, w_cols[i][k]});
                end
            end
        end
    end

    always_comb begin
        if (w_sum < 0) begin
            o_gray = '0;
        end else if (w_sum > SUM_W'(GRAY_MAX)) begin
            o_gray = lo3_pkg::PIX_W'(GRAY_MAX);
        end else begin
            o_gray = w_sum[lo3_pkg::PIX_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/laplacian_outline_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_outline_3x3
// Streaming 3x3 Laplacian outline filter with zero padding.
//
// Input requests (i_valid/o_stall) carry a mode bit and a red byte; mode 0
// is a pixel in raster order, mode 1 a drain request. Output requests
// (o_valid/i_stall) carry the clamped gray value and a frame-last flag.
// Output k of a frame is completed by input k+W+1, so W+1 drain requests
// flush a frame after its last pixel. Drains during a frame, and pixels
// after a full frame, are dropped without a result.
// Throughput: one request per cycle while o_stall is low. A result passes
// the line store read, the window shift and the combinational kernel into
// the output buffer, and shows on o_valid once written there. Per-column
// line store access is one read and one write of a single memory; a
// width-one frame uses a write bypass. Results queue in a four-entry output
// buffer; o_stall rises when held plus in-flight results would fill it, so a
// stalled receiver blocks the input before the buffer can overflow. Reset
// (synchronous, active low) restores 640x480, restarts the frame and empties
// the pipeline; the line stores are not cleared, as rows above the frame are
// masked. A write to the width or height register also restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_outline_3x3 #(
    parameter int MAX_WIDTH  = lo3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lo3_pkg::MAX_HEIGHT_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  lo3_pkg::t_in_item                  i_data,
    output logic                               o_valid,
    input  wire                                i_stall,
    output lo3_pkg::t_out_item                 o_data,
    input  wire                                i_cfg_we,
    input  wire  [lo3_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [lo3_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int RW    = $clog2(MAX_HEIGHT + 3);
    localparam int DEPTH = lo3_pkg::OUT_QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int CRW   = $clog2(DEPTH + 3);
    localparam int W_RST = (lo3_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                           MAX_WIDTH : lo3_pkg::FRAME_WIDTH_RST;
    localparam int H_RST = (lo3_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                           MAX_HEIGHT : lo3_pkg::FRAME_HEIGHT_RST;

    // ---------------- frame geometry and stream position ----------------
    logic [WW-1:0] r_w, n_w;
    logic [HW-1:0] r_h, n_h;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_cx, n_cx;
    logic [YW-1:0] r_cy, n_cy;

    logic [WW-1:0]   w_cfg_w;
    logic [HW-1:0]   w_cfg_h;
    logic            w_acc;
    logic            w_drain;
    logic            w_row_in;
    logic            w_proc;
    logic            w_emit;
    logic            w_col_wrap;
    logic            w_cx_wrap;
    logic            w_cy_wrap;
    logic            w_done;
    lo3_pkg::t_pix   w_pix;
    lo3_pkg::t_ctrl  w_ctrl;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_w = WW'(1);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            w_cfg_w = WW'(MAX_WIDTH);
        end else begin
            w_cfg_w = WW'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            w_cfg_h = HW'(1);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            w_cfg_h = HW'(MAX_HEIGHT);
        end else begin
            w_cfg_h = HW'(i_cfg_data);
        end
    end

    assign w_acc      = i_valid && !o_stall;
    assign w_drain    = i_data.mode;
    assign w_row_in   = r_row < RW'(r_h);
    assign w_proc     = w_acc && (w_drain ^ w_row_in);
    assign w_pix      = w_drain ? '0 : i_data.red_in;
    assign w_emit     = (r_row >= RW'(2)) || ((r_row == RW'(1)) && (r_col != '0));
    assign w_col_wrap = (WW'(r_col) + WW'(1)) >= r_w;
    assign w_cx_wrap  = (WW'(r_cx) + WW'(1)) >= r_w;
    assign w_cy_wrap  = (HW'(r_cy) + HW'(1)) >= r_h;
    assign w_done     = w_cx_wrap && w_cy_wrap;

    always_comb begin
        w_ctrl.mask.top_ok   = r_cy != '0;
        w_ctrl.mask.bot_ok   = !w_cy_wrap;
        w_ctrl.mask.left_ok  = r_cx != '0;
        w_ctrl.mask.right_ok = !w_cx_wrap;
        w_ctrl.last          = w_done;
        w_ctrl.emit          = w_emit;
    end

    always_comb begin
        n_w   = r_w;
        n_h   = r_h;
        n_col = r_col;
        n_row = r_row;
        n_cx  = r_cx;
        n_cy  = r_cy;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lo3_pkg::CFG_FRAME_WIDTH: begin
                    n_w   = w_cfg_w;
                    n_col = '0;
                    n_row = '0;
                    n_cx  = '0;
                    n_cy  = '0;
                end
                lo3_pkg::CFG_FRAME_HEIGHT: begin
                    n_h   = w_cfg_h;
                    n_col = '0;
                    n_row = '0;
                    n_cx  = '0;
                    n_cy  = '0;
                end
                default: begin
                end
            endcase
        end else if (w_proc) begin
            if (w_col_wrap) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
            if (w_emit) begin
                if (w_done) begin
                    // last output of the frame: restart position and count
                    n_col = '0;
                    n_row = '0;
                    n_cx  = '0;
                    n_cy  = '0;
                end else if (w_cx_wrap) begin
                    n_cx = '0;
                    n_cy = r_cy + YW'(1);
                end else begin
                    n_cx = r_cx + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= WW'(W_RST);
            r_h   <= HW'(H_RST);
            r_col <= '0;
            r_row <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
        end else begin
            r_w   <= n_w;
            r_h   <= n_h;
            r_col <= n_col;
            r_row <= n_row;
            r_cx  <= n_cx;
            r_cy  <= n_cy;
        end
    end

    // ---------------- line store stage ----------------
    logic                r_s1_valid;
    logic [CW-1:0]       r_s1_col;
    lo3_pkg::t_pix       r_s1_pix;
    lo3_pkg::t_ctrl      r_s1_ctrl;
    logic                r_fwd;
    lo3_pkg::t_pix       r_fwd_mid;
    lo3_pkg::t_pix       r_fwd_pix;
    lo3_pkg::t_line_word w_rd;
    lo3_pkg::t_line_word w_wr;
    lo3_pkg::t_pix       w_s1_above;
    lo3_pkg::t_pix       w_s1_mid;

    // same column written by the request ahead: bypass the stale read
    assign w_s1_above = r_fwd ? r_fwd_mid : w_rd.older;
    assign w_s1_mid   = r_fwd ? r_fwd_pix : w_rd.newer;
    assign w_wr.older = w_s1_mid;
    assign w_wr.newer = r_s1_pix;

    lo3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_raddr (r_col),
        .o_rdata (w_rd),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (w_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_proc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col  <= r_col;
        r_s1_pix  <= w_pix;
        r_s1_ctrl <= w_ctrl;
        r_fwd     <= r_s1_valid && (r_s1_col == r_col);
        r_fwd_mid <= w_s1_mid;
        r_fwd_pix <= r_s1_pix;
    end

    // ---------------- window cells ----------------
    lo3_pkg::t_col3 w_chain [lo3_pkg::WIN_COLS + 1];

    assign w_chain[lo3_pkg::WIN_COLS][0] = w_s1_above;
    assign w_chain[lo3_pkg::WIN_COLS][1] = w_s1_mid;
    assign w_chain[lo3_pkg::WIN_COLS][2] = r_s1_pix;

    for (genvar j = 0; j < lo3_pkg::WIN_COLS; j++) begin : g_cell
        lo3_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_s1_valid),
            .i_col   (w_chain[j + 1]),
            .o_col   (w_chain[j])
        );
    end

    // ---------------- kernel stage ----------------
    logic           r_s2_valid;
    lo3_pkg::t_ctrl r_s2_ctrl;
    lo3_pkg::t_pix  w_gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ctrl <= r_s1_ctrl;
    end

    lo3_kernel u_kernel (
        .i_left   (w_chain[0]),
        .i_center (w_chain[1]),
        .i_right  (w_chain[2]),
        .i_mask   (r_s2_ctrl.mask),
        .o_gray   (w_gray)
    );

    // ---------------- output queue ----------------
    lo3_pkg::t_out_item r_queue [DEPTH];
    logic [PW-1:0]      r_wr_ptr;
    logic [PW-1:0]      r_rd_ptr;
    logic [CNTW-1:0]    r_count;
    logic               w_push;
    logic               w_pop;
    logic [CRW-1:0]     w_credit;
    lo3_pkg::t_out_item w_push_item;

    assign w_push               = r_s2_valid;
    assign w_pop                = o_valid && !i_stall;
    assign w_push_item.gray_out   = w_gray;
    assign w_push_item.frame_last = r_s2_ctrl.last;

    // held results plus every request in the line store stage and every result in the kernel stage
    assign w_credit = CRW'(r_count) + CRW'(r_s1_valid) + CRW'(r_s2_valid);
    assign o_stall  = w_credit >= CRW'(DEPTH);
    assign o_valid  = r_count != '0;
    assign o_data   = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    // ---------------- assertions ----------------
    a_credit_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_credit <= CRW'(DEPTH)
    ) else $error("output queue credit exceeded");

    a_col_in_line: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < r_w
    ) else $error("input column outside line");

    a_out_col_in_line: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_cx) < r_w
    ) else $error("output column outside line");

    a_last_restarts: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_emit && w_done && !i_cfg_we) |=> (r_cx == '0 && r_cy == '0)
    ) else $error("frame not restarted after last output");

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 Laplacian outline filter. Frames of random
// and extreme pixel data go through the block under several frame sizes,
// with ignored drains, dropped pixels and cut frames mixed in. A built-in
// line store and window model predicts every gray value and frame-last flag,
// and results are compared in order as they leave the block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lo3_pkg::*;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = CFG_IDX_W'(3);

    localparam int unsigned RANDOM_ITEMS  = 1850;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_valid    = 1'b0;
    logic                   o_stall;
    t_in_item               i_data     = '0;
    logic                   o_valid;
    logic                   i_stall    = 1'b0;
    t_out_item              o_data;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    laplacian_outline_3x3 u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_in_item    pixel_stream[$];
    t_out_item   gray_expected[$];

    int unsigned cycle_count       = 0;
    int unsigned requests_accepted = 0;
    int unsigned results_checked   = 0;
    int unsigned mismatches        = 0;
    int unsigned config_writes     = 0;
    int unsigned frames_queued     = 0;
    int unsigned random_items      = 0;
    int unsigned cur_w             = FRAME_WIDTH_RST;
    int unsigned cur_h             = FRAME_HEIGHT_RST;

    // ------------------------------------------------------------------------
    // Outline predictor state
    // ------------------------------------------------------------------------
    int unsigned frame_w, frame_h;
    int unsigned col_pos, row_pos, out_idx;
    t_pix        store_older [MAX_WIDTH_DEF];
    t_pix        store_newer [MAX_WIDTH_DEF];
    t_col3       win_px [WIN_COLS];  // [2] is the newest column

    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void restart_outline();
        col_pos = 0;
        row_pos = 0;
        out_idx = 0;
    endfunction

    function automatic void reset_outline();
        frame_w = FRAME_WIDTH_RST;
        frame_h = FRAME_HEIGHT_RST;
        for (int n = 0; n < MAX_WIDTH_DEF; n++) begin
            store_older[n] = '0;
            store_newer[n] = '0;
        end
        for (int n = 0; n < WIN_COLS; n++) win_px[n] = '0;
        restart_outline();
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_FRAME_WIDTH: begin
                frame_w = clamp_dim(value, MAX_WIDTH_DEF);
                restart_outline();
            end
            CFG_FRAME_HEIGHT: begin
                frame_h = clamp_dim(value, MAX_HEIGHT_DEF);
                restart_outline();
            end
            default: ;
        endcase
    endfunction

    // Advance the window by one request; return 1 when it completes an output.
    function automatic bit predict_outline(input t_in_item req, output t_out_item res);
        int unsigned total, pos, cx, cy, cidx;
        t_pix        pix, above, mid;
        int          sum;
        bit          drain;

        res   = '0;
        total = frame_w * frame_h;
        drain = (req.mode == MODE_DRAIN);
        pix   = drain ? '0 : req.red_in;
        // drop drains mid-frame and pixels once the frame is complete
        if (drain ? (row_pos < frame_h) : (row_pos >= frame_h)) return 0;
        cidx = (col_pos >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_pos;
        pos  = row_pos * frame_w + col_pos;

        above = store_older[cidx];
        mid   = store_newer[cidx];
        store_older[cidx] = mid;
        store_newer[cidx] = pix;
        win_px[0] = win_px[1];
        win_px[1] = win_px[2];
        win_px[2] = {pix, mid, above};

        col_pos++;
        if (col_pos >= frame_w) begin
            col_pos = 0;
            row_pos++;
        end
        if (pos < frame_w + 1) return 0;

        cx  = out_idx % frame_w;
        cy  = out_idx / frame_w;
        sum = 0;
        for (int i = 0; i < WIN_COLS; i++) begin
            if ((i == 0 && cx == 0) || (i == 2 && cx + 1 >= frame_w)) continue;
            for (int k = 0; k < WIN_ROWS; k++) begin
                if ((k == 0 && cy == 0) || (k == 2 && cy + 1 >= frame_h)) continue;
                if (i == 1 && k == 1) sum += 8 * int'(win_px[i][k]);
                else                  sum -= int'(win_px[i][k]);
            end
        end
        if (sum < 0)   sum = 0;
        if (sum > 255) sum = 255;

        res.gray_out   = t_pix'(sum);
        res.frame_last = (out_idx + 1 >= total);
        if (res.frame_last) restart_outline();
        else                out_idx++;
        return 1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one request per slot, random gap after each
    // ------------------------------------------------------------------------
    int unsigned tx_gap  = 0;
    bit          tx_calm = 1'b0;

    always @(posedge i_clk) begin : sender
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else if (!i_valid || !o_stall) begin
            if (tx_gap > 0) begin
                i_valid <= 1'b0;
                tx_gap--;
            end else if (pixel_stream.size() != 0) begin
                i_valid <= 1'b1;
                i_data  <= pixel_stream.pop_front();
                if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : $urandom_range(0, 10);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall after each result, plus a few long hold-offs
    // ------------------------------------------------------------------------
    int unsigned rx_hold        = 0;
    int unsigned rx_taken       = 0;
    int unsigned next_long_hold = 300;
    bit          rx_calm        = 1'b0;

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                rx_taken++;
                if (rx_taken >= next_long_hold && i_valid) begin
                    // hold off while requests keep coming so the block backs up
                    rx_hold = LONG_HOLD;
                    next_long_hold += 900;
                end else begin
                    if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
                    rx_hold = rx_calm ? 0 : $urandom_range(0, 10);
                end
            end else if (rx_hold == 0 && !rx_calm && $urandom_range(0, 15) == 0) begin
                rx_hold = $urandom_range(1, 10);
            end
            if (rx_hold > 0) begin
                i_stall <= 1'b1;
                rx_hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: predict on each accepted request, check each accepted result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_out_item pred;
        t_out_item want;

        if (!i_rst_n) begin
            reset_outline();
        end else begin
            if (i_cfg_we) apply_register(i_cfg_idx, i_cfg_data);
            if (i_valid && !o_stall) begin
                requests_accepted++;
                if (predict_outline(i_data, pred)) gray_expected.push_back(pred);
            end
            if (o_valid && !i_stall) begin
                results_checked++;
                if (gray_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, actual gray_out %0d frame_last %0d",
                             $time, o_data.gray_out, o_data.frame_last);
                end else begin
                    want = gray_expected.pop_front();
                    if (o_data.gray_out !== want.gray_out) begin
                        mismatches++;
                        $display("%0t: gray_out mismatch, expected %0d, actual %0d",
                                 $time, want.gray_out, o_data.gray_out);
                    end
                    if (o_data.frame_last !== want.frame_last) begin
                        mismatches++;
                        $display("%0t: frame_last mismatch, expected %0d, actual %0d",
                                 $time, want.frame_last, o_data.frame_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_pix random_red();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_request(input logic mode, input t_pix red);
        t_in_item req;
        req.mode   = mode;
        req.red_in = red;
        pixel_stream.push_back(req);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        config_writes++;
    endtask

    // Hold until every request is in and every result is out, then let the
    // pipeline settle past any request that produced nothing.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_stream.size() != 0 || i_valid || gray_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h);
        logic [CFG_DATA_W-1:0] wv, hv;

        // a zero write clamps to one
        wv = (w == 1 && $urandom_range(0, 1)) ? '0 : CFG_DATA_W'(w);
        hv = (h == 1 && $urandom_range(0, 1)) ? '0 : CFG_DATA_W'(h);
        if ($urandom_range(0, 7) == 0)
            write_register($urandom_range(0, 1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B,
                           CFG_DATA_W'($urandom_range(0, 2047)));
        if ($urandom_range(0, 1)) begin
            write_register(CFG_FRAME_WIDTH, wv);
            write_register(CFG_FRAME_HEIGHT, hv);
        end else begin
            write_register(CFG_FRAME_HEIGHT, hv);
            write_register(CFG_FRAME_WIDTH, wv);
        end
        cur_w = w;
        cur_h = h;
    endtask

    // One frame plus its flush. A non-zero keep cuts the frame after that many
    // pixels and drains; noise adds ignored drains and dropped pixels.
    task automatic queue_frame(input int unsigned w, input int unsigned h,
                               input bit noisy, input int unsigned keep);
        int unsigned left;

        left = (keep == 0) ? w * h + w + 1 : keep;
        for (int unsigned k = 0; k < w * h && left > 0; k++) begin
            if (noisy && $urandom_range(0, 7) == 0) queue_request(MODE_DRAIN, random_red());
            queue_request(MODE_PIXEL, random_red());
            left--;
        end
        if (noisy && left > 0)
            repeat ($urandom_range(1, 3)) queue_request(MODE_PIXEL, random_red());
        for (int unsigned k = 0; k <= w && left > 0; k++) begin
            queue_request(MODE_DRAIN, random_red());
            left--;
            // stray pixel before the last drain is dropped
            if (noisy && k < w && $urandom_range(0, 5) == 0)
                queue_request(MODE_PIXEL, random_red());
        end
        if (noisy && keep == 0) queue_request(MODE_DRAIN, random_red());
        frames_queued++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned w, h, keep;
        bit          noisy, restart_needed;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x2 checkerboard with a drain mid-frame and a pixel after the frame
        write_register(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
        write_register(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
        queue_request(MODE_DRAIN, 8'hFF);
        queue_request(MODE_PIXEL, 8'hFF);
        queue_request(MODE_PIXEL, 8'h00);
        queue_request(MODE_PIXEL, 8'hFF);
        queue_request(MODE_DRAIN, 8'h00);
        queue_request(MODE_PIXEL, 8'h00);
        queue_request(MODE_PIXEL, 8'hFF);
        queue_request(MODE_PIXEL, 8'h00);
        queue_request(MODE_PIXEL, 8'h5A);
        repeat (4) queue_request(MODE_DRAIN, 8'hA5);
        queue_request(MODE_DRAIN, 8'h00);
        frames_queued++;
        wait_idle();

        // single-line frame, height written as zero
        write_register(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
        write_register(CFG_FRAME_HEIGHT, '0);
        queue_request(MODE_PIXEL, 8'h80);
        queue_request(MODE_PIXEL, 8'h7F);
        repeat (3) queue_request(MODE_DRAIN, 8'h00);
        frames_queued++;
        wait_idle();

        // unmapped indexes, then a one-pixel-wide column
        write_register(CFG_UNMAPPED_A, '1);
        write_register(CFG_UNMAPPED_B, '0);
        write_register(CFG_FRAME_WIDTH, '0);
        write_register(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
        queue_request(MODE_PIXEL, 8'h00);
        queue_request(MODE_PIXEL, 8'hFF);
        queue_request(MODE_PIXEL, 8'h00);
        repeat (2) queue_request(MODE_DRAIN, 8'hFF);
        frames_queued++;
        wait_idle();

        // widest line, clamped from above, cut short after part of the flush
        write_register(CFG_FRAME_WIDTH, '1);
        write_register(CFG_FRAME_HEIGHT, '0);
        queue_frame(MAX_WIDTH_DEF, 1, 1'b0, MAX_WIDTH_DEF + 40);
        wait_idle();

        // tallest frame, one pixel wide
        write_register(CFG_FRAME_WIDTH, '0);
        write_register(CFG_FRAME_HEIGHT, '1);
        queue_frame(1, MAX_HEIGHT_DEF, 1'b0, 0);

        restart_needed = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 11) == 0) begin
                w = $urandom_range(9, 40);
                h = $urandom_range(2, 4);
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
            end
            if (restart_needed || $urandom_range(0, 2) != 0) begin
                wait_idle();
                configure(w, h);
            end else begin
                w = cur_w;
                h = cur_h;
            end
            noisy = ($urandom_range(0, 3) == 0);
            keep  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h + w) : 0;
            restart_needed = (keep != 0);
            queue_frame(w, h, noisy, keep);
            random_items += (keep != 0) ? keep : w * h + w + 1;
        end
        wait_idle();

        $display("Run covered %0d frames, %0d register writes, %0d requests accepted",
                 frames_queued, config_writes, requests_accepted);
        $display("and %0d results checked, with %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && gray_expected.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d results still expected", gray_expected.size());
            $display("tb failed");
        end
        $finish;
    end

endmodule
